// ===== src/wllm_pkg.sv =====
// Shared constants, types and helper functions for the window latency and load monitor.
`default_nettype none
package wllm_pkg;

  localparam int MAX_MEMORIES = 16;
  localparam int COUNT_BITS   = 24;
  localparam int SUM_BITS     = 40;
  localparam int AVG_BITS     = 16;
  localparam int OUT_CNT_W    = 24;
  localparam int TOTAL_W      = 25;
  localparam int ID_W         = 8;
  localparam int LAT_W        = 16;
  localparam int OP_W         = 2;
  localparam int SLOT_W       = (MAX_MEMORIES > 1) ? $clog2(MAX_MEMORIES) : 1;
  localparam int USED_W       = $clog2(MAX_MEMORIES + 1);
  localparam int STEP_W       = $clog2(SUM_BITS + 1);
  localparam int IN_DATA_W    = 24;
  localparam int IN_USER_W    = 3;
  localparam int OUT_DATA_W   = 168;

  localparam logic [OP_W-1:0] OP_SELECT = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;

  localparam logic FUNC_EVENT = 1'b0;
  localparam logic FUNC_CLOSE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVENT,
    ST_RAVG_START,
    ST_RAVG_WAIT,
    ST_WAVG_START,
    ST_WAVG_WAIT,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]       ident;
    logic [COUNT_BITS-1:0] rw_count;
    logic [COUNT_BITS-1:0] all_count;
  } slot_row_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic logic [OUT_CNT_W-1:0] clamp_cnt(input logic [COUNT_BITS-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'((1 << OUT_CNT_W) - 1)) ? {OUT_CNT_W{1'b1}} : w[OUT_CNT_W-1:0];
  endfunction

  function automatic logic [TOTAL_W-1:0] clamp_total(input logic [COUNT_BITS-1:0] a,
                                                     input logic [COUNT_BITS-1:0] b);
    logic [33:0] w;
    w = 34'(a) + 34'(b);
    return (w > 34'((1 << TOTAL_W) - 1)) ? {TOTAL_W{1'b1}} : w[TOTAL_W-1:0];
  endfunction

  function automatic logic [SUM_BITS-1:0] sat_add_sum(input logic [SUM_BITS-1:0] s,
                                                      input logic [LAT_W-1:0] lat);
    logic [SUM_BITS:0] w;
    w = {1'b0, s} + (SUM_BITS + 1)'(lat);
    return w[SUM_BITS] ? {SUM_BITS{1'b1}} : w[SUM_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/wllm_div.sv =====
// Bit-serial restoring divider: latency sum over count, saturated to the average width.
`default_nettype none
module wllm_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [wllm_pkg::SUM_BITS-1:0]     dividend,
  input  wire logic [wllm_pkg::COUNT_BITS-1:0]   divisor,
  output wllm_pkg::div_stat_t                    stat,
  output logic [wllm_pkg::AVG_BITS-1:0]          quotient
);

  logic                              busy;
  logic                              done;
  logic [wllm_pkg::STEP_W-1:0]       step;
  logic [wllm_pkg::SUM_BITS-1:0]     quot;
  logic [wllm_pkg::COUNT_BITS:0]     rem;
  logic [wllm_pkg::COUNT_BITS-1:0]   dsr;
  logic [wllm_pkg::COUNT_BITS:0]     shifted;
  logic [wllm_pkg::COUNT_BITS+1:0]   trial;
  logic                              fits;

  always_comb begin
    shifted = {rem[wllm_pkg::COUNT_BITS-1:0], quot[wllm_pkg::SUM_BITS-1]};
    trial   = {1'b0, shifted} - (wllm_pkg::COUNT_BITS + 2)'(dsr);
    fits    = !trial[wllm_pkg::COUNT_BITS+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + wllm_pkg::STEP_W'(1);
        if (step == wllm_pkg::STEP_W'(wllm_pkg::SUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      quot <= {quot[wllm_pkg::SUM_BITS-2:0], fits};
      rem  <= fits ? trial[wllm_pkg::COUNT_BITS:0] : shifted;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = (|quot[wllm_pkg::SUM_BITS-1:wllm_pkg::AVG_BITS]) ?
                     {wllm_pkg::AVG_BITS{1'b1}} : quot[wllm_pkg::AVG_BITS-1:0];

endmodule
`default_nettype wire

// ===== src/wllm_slots.sv =====
// Per-memory slot table with parallel id match, saturating counts and overflow flag.
`default_nettype none
module wllm_slots (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            upd,
  input  wire logic                            clear,
  input  wire logic [wllm_pkg::OP_W-1:0]       op_kind,
  input  wire logic [wllm_pkg::ID_W-1:0]       memory_id,
  input  wire logic [wllm_pkg::SLOT_W-1:0]     rd_idx,
  output wllm_pkg::slot_row_t                  row,
  output logic [wllm_pkg::USED_W-1:0]          slots_used,
  output logic                                 overflow
);

  logic [wllm_pkg::ID_W-1:0]       slot_ident     [wllm_pkg::MAX_MEMORIES];
  logic [wllm_pkg::COUNT_BITS-1:0] slot_rw_count  [wllm_pkg::MAX_MEMORIES];
  logic [wllm_pkg::COUNT_BITS-1:0] slot_all_count [wllm_pkg::MAX_MEMORIES];

  logic                        hit;
  logic [wllm_pkg::SLOT_W-1:0] hit_idx;
  logic [wllm_pkg::SLOT_W-1:0] addr;
  logic                        has_room;
  logic                        is_rw;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < wllm_pkg::MAX_MEMORIES; i++) begin
      if (wllm_pkg::USED_W'(i) < slots_used && slot_ident[i] == memory_id) begin
        hit     = 1'b1;
        hit_idx = wllm_pkg::SLOT_W'(i);
      end
    end
  end

  assign has_room = slots_used < wllm_pkg::USED_W'(wllm_pkg::MAX_MEMORIES);
  assign is_rw    = (op_kind == wllm_pkg::OP_SELECT) || (op_kind == wllm_pkg::OP_INSERT);
  assign addr     = upd ? (hit ? hit_idx : wllm_pkg::SLOT_W'(slots_used)) : rd_idx;

  assign row.ident     = slot_ident[addr];
  assign row.rw_count  = slot_rw_count[addr];
  assign row.all_count = slot_all_count[addr];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      slots_used <= '0;
      overflow   <= 1'b0;
    end else if (upd) begin
      if (!hit && has_room) begin
        slots_used <= slots_used + wllm_pkg::USED_W'(1);
      end else if (!hit) begin
        overflow <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd && !clear) begin
      if (hit) begin
        if (is_rw) begin
          slot_rw_count[addr] <= wllm_pkg::sat_inc(row.rw_count);
        end
        slot_all_count[addr] <= wllm_pkg::sat_inc(row.all_count);
      end else if (has_room) begin
        slot_ident[addr]     <= memory_id;
        slot_rw_count[addr]  <= is_rw ? wllm_pkg::COUNT_BITS'(1) : '0;
        slot_all_count[addr] <= wllm_pkg::COUNT_BITS'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/window_latency_load_monitor.sv =====
// Top level: event counting, window-close sequencer and report stream.
// Event item: accepted, then applied in the next cycle; no item is taken meanwhile.
// Close item: read and then write average through the shared 40-step serial divider (a
//   division is skipped when its count is zero), then one report row per seen memory (at
//   least one), each held until the sink takes it. No item is accepted until the last row
//   is taken.
// Synchronous active-high reset clears window totals and sums, slot fill count, overflow.
`default_nettype none
module window_latency_load_monitor (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // memory_id [7:0], latency [23:8]
  input  wire logic [wllm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // func [0], op_kind [2:1]
  input  wire logic [wllm_pkg::IN_USER_W-1:0]       s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // read_count [23:0], read_latency_avg [39:24], write_count [63:40],
  // write_latency_avg [79:64], total_rw [104:80], memory_ident [112:105],
  // memory_rw_count [136:113], memory_all_count [160:137], table_overflow [161]
  output logic [wllm_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
  // memory_valid [0]
  output logic                                      m_axis_tuser,
  output logic                                      m_axis_tlast
);

  wllm_pkg::state_t state, state_next;

  logic [wllm_pkg::OP_W-1:0]       op_r;
  logic [wllm_pkg::ID_W-1:0]       id_r;
  logic [wllm_pkg::LAT_W-1:0]      lat_r;
  logic [wllm_pkg::COUNT_BITS-1:0] select_total;
  logic [wllm_pkg::COUNT_BITS-1:0] insert_total;
  logic [wllm_pkg::SUM_BITS-1:0]   select_latency_sum;
  logic [wllm_pkg::SUM_BITS-1:0]   insert_latency_sum;
  logic [wllm_pkg::AVG_BITS-1:0]   read_avg;
  logic [wllm_pkg::AVG_BITS-1:0]   write_avg;
  logic [wllm_pkg::SLOT_W-1:0]     row_idx;

  logic                            in_acc;
  logic                            out_acc;
  logic                            slot_upd;
  logic                            div_start;
  logic                            row_last;
  logic [wllm_pkg::SUM_BITS-1:0]   div_dividend;
  logic [wllm_pkg::COUNT_BITS-1:0] div_divisor;
  logic [wllm_pkg::AVG_BITS-1:0]   div_quot;
  wllm_pkg::div_stat_t             div_stat;
  wllm_pkg::slot_row_t             row;
  logic [wllm_pkg::USED_W-1:0]     slots_used;
  logic                            overflow;
  logic                            mem_valid;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  wllm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  wllm_slots u_slots (
    .clk        (clk),
    .rst        (rst),
    .upd        (slot_upd),
    .clear      (out_acc && row_last),
    .op_kind    (op_r),
    .memory_id  (id_r),
    .rd_idx     (row_idx),
    .row        (row),
    .slots_used (slots_used),
    .overflow   (overflow)
  );

  always_comb begin
    state_next = state;
    case (state)
      wllm_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = (s_axis_tuser[0] == wllm_pkg::FUNC_CLOSE) ?
                       wllm_pkg::ST_RAVG_START : wllm_pkg::ST_EVENT;
        end
      end
      wllm_pkg::ST_EVENT:      state_next = wllm_pkg::ST_IDLE;
      wllm_pkg::ST_RAVG_START: begin
        state_next = (select_total == '0) ? wllm_pkg::ST_WAVG_START : wllm_pkg::ST_RAVG_WAIT;
      end
      wllm_pkg::ST_RAVG_WAIT: begin
        if (div_stat.done) state_next = wllm_pkg::ST_WAVG_START;
      end
      wllm_pkg::ST_WAVG_START: begin
        state_next = (insert_total == '0) ? wllm_pkg::ST_SEND : wllm_pkg::ST_WAVG_WAIT;
      end
      wllm_pkg::ST_WAVG_WAIT: begin
        if (div_stat.done) state_next = wllm_pkg::ST_SEND;
      end
      wllm_pkg::ST_SEND: begin
        if (out_acc && row_last) state_next = wllm_pkg::ST_IDLE;
      end
      default: state_next = wllm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    slot_upd      = 1'b0;
    div_start     = 1'b0;
    div_dividend  = select_latency_sum;
    div_divisor   = select_total;
    case (state)
      wllm_pkg::ST_IDLE:       s_axis_tready = 1'b1;
      wllm_pkg::ST_EVENT:      slot_upd = 1'b1;
      wllm_pkg::ST_RAVG_START: div_start = (select_total != '0);
      wllm_pkg::ST_WAVG_START: begin
        div_start    = (insert_total != '0);
        div_dividend = insert_latency_sum;
        div_divisor  = insert_total;
      end
      wllm_pkg::ST_SEND:       m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wllm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      select_total       <= '0;
      insert_total       <= '0;
      select_latency_sum <= '0;
      insert_latency_sum <= '0;
    end else if (out_acc && row_last) begin
      select_total       <= '0;
      insert_total       <= '0;
      select_latency_sum <= '0;
      insert_latency_sum <= '0;
    end else if (state == wllm_pkg::ST_EVENT) begin
      if (op_r == wllm_pkg::OP_SELECT) begin
        select_total       <= wllm_pkg::sat_inc(select_total);
        select_latency_sum <= wllm_pkg::sat_add_sum(select_latency_sum, lat_r);
      end else if (op_r == wllm_pkg::OP_INSERT) begin
        insert_total       <= wllm_pkg::sat_inc(insert_total);
        insert_latency_sum <= wllm_pkg::sat_add_sum(insert_latency_sum, lat_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= s_axis_tuser[2:1];
      id_r  <= s_axis_tdata[7:0];
      lat_r <= s_axis_tdata[23:8];
    end
    if (in_acc) begin
      row_idx <= '0;
    end else if (out_acc) begin
      row_idx <= row_idx + wllm_pkg::SLOT_W'(1);
    end
    if (state == wllm_pkg::ST_RAVG_START) begin
      read_avg <= '0;
    end else if (state == wllm_pkg::ST_RAVG_WAIT && div_stat.done) begin
      read_avg <= div_quot;
    end
    if (state == wllm_pkg::ST_WAVG_START) begin
      write_avg <= '0;
    end else if (state == wllm_pkg::ST_WAVG_WAIT && div_stat.done) begin
      write_avg <= div_quot;
    end
  end

  assign mem_valid = (slots_used != '0);
  assign row_last  = !mem_valid ||
                     (wllm_pkg::USED_W'(row_idx) + wllm_pkg::USED_W'(1) == slots_used);

  assign m_axis_tdata = {
    6'd0,
    overflow,
    mem_valid ? wllm_pkg::clamp_cnt(row.all_count) : wllm_pkg::OUT_CNT_W'(0),
    mem_valid ? wllm_pkg::clamp_cnt(row.rw_count)  : wllm_pkg::OUT_CNT_W'(0),
    mem_valid ? row.ident : wllm_pkg::ID_W'(0),
    wllm_pkg::clamp_total(select_total, insert_total),
    write_avg,
    wllm_pkg::clamp_cnt(insert_total),
    read_avg,
    wllm_pkg::clamp_cnt(select_total)
  };
  assign m_axis_tuser = mem_valid;
  assign m_axis_tlast = row_last;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a report row is offered");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_axis_tready)
    else $error("ready again right after an accepted item");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == wllm_pkg::ST_RAVG_WAIT || state == wllm_pkg::ST_WAVG_WAIT))
    else $error("divider finished outside a wait state");

  a_clear_after_report: assert property (@(posedge clk) disable iff (rst)
    out_acc && m_axis_tlast |=> (select_total == '0 && insert_total == '0 &&
                                 slots_used == '0 && !overflow))
    else $error("window state not cleared after the final report row");

  a_div_idle_at_send: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !div_stat.busy)
    else $error("divider still running while the report is sent");

endmodule
`default_nettype wire
